>>> rtl/mfs_pkg.sv
// Shared types, codes and helpers for the multilevel feedback scheduler.
`timescale 1ns / 1ps

package mfs_pkg;

    localparam int PROC_COUNT_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int ID_W      = 3;
    localparam int LVL_W     = 2;
    localparam int SLICE_W   = 8;
    localparam int OP_W      = 2;
    localparam int OC_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Three priority levels plus the I/O wait queue
    localparam int LEVEL_COUNT = 3;
    localparam int QUEUE_COUNT = 4;
    localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd2;
    localparam logic [LVL_W-1:0] IO_QUEUE   = 2'd3;

    localparam logic [SLICE_W-1:0] SLICE0_RST = 8'd1;
    localparam logic [SLICE_W-1:0] SLICE1_RST = 8'd2;
    localparam logic [SLICE_W-1:0] SLICE2_RST = 8'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LEVEL0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LEVEL1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LEVEL2 = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADMIT    = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REPORT   = 2'd2,
        OP_IO_DONE  = 2'd3
    } t_op;

    typedef enum logic [OC_W-1:0] {
        OC_FINISHED = 2'd0,
        OC_IO_REQ   = 2'd1,
        OC_EXPIRED  = 2'd2
    } t_outcome;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NORUN = 2'd3
    } t_status;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] id;
    } t_q_ctrl;

    typedef struct packed {
        logic [ID_W-1:0] head_id;
        logic            empty;
        logic            full;
    } t_q_stat;

    // id modulo the process count; ids are narrow so three subtract steps suffice for a process count of two or more
    function automatic logic [ID_W-1:0] slot_of(input logic [ID_W-1:0] id, input int pc);
        int v;
        v = int'(id);
        for (int k = 0; k < 3; k++) begin
            if (v >= pc) begin
                v = v - pc;
            end
        end
        return ID_W'(v);
    endfunction

    function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lv);
        return (lv > LVL_BOTTOM) ? LVL_BOTTOM : lv;
    endfunction

endpackage

>>> rtl/mfs_if.sv
// Handshake channels of the scheduler: command, result and configuration write.
`timescale 1ns / 1ps

interface mfs_cmd_if import mfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   process_id;
    logic [OC_W-1:0]   outcome;

    modport source (output valid, output operation, output process_id, output outcome,
                    input ready);
    modport sink   (input valid, input operation, input process_id, input outcome,
                    output ready);
endinterface

interface mfs_res_if import mfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     granted_id;
    logic [LVL_W-1:0]    granted_level;
    logic [SLICE_W-1:0]  granted_slice;
    logic                valid_res;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output granted_id, output granted_level,
                    output granted_slice, output valid_res, output status, input ready);
    modport sink   (input valid, input granted_id, input granted_level,
                    input granted_slice, input valid_res, input status, output ready);
endinterface

interface mfs_cfg_if import mfs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SLICE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/mfs_queue.sv
// Circular id queue with a registered head entry read ahead from its memory.
`timescale 1ns / 1ps

module mfs_queue import mfs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_ctrl i_ctrl,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_head_data;
    logic [PW-1:0]   r_head;
    logic [CW-1:0]   r_count;

    logic [CW:0]     tail_sum;
    logic [CW:0]     tail_wrap;
    logic [PW-1:0]   tail;
    logic [PW:0]     head_inc;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   n_head;
    logic [CW-1:0]   n_count;

    always_comb begin
        tail_sum  = (CW + 1)'(r_head) + (CW + 1)'(r_count);
        tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
        tail      = tail_wrap[PW-1:0];
        head_inc  = (PW + 1)'(r_head) + (PW + 1)'(1);
        head_next = (head_inc == (PW + 1)'(DEPTH)) ? '0 : head_inc[PW-1:0];
        n_head    = i_ctrl.pop ? head_next : r_head;
        n_count   = r_count + CW'(i_ctrl.push) - CW'(i_ctrl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Memory and read-ahead head; bypass when the beat lands on the new head slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[tail] <= i_ctrl.id;
        end
        if (i_ctrl.push && (tail == n_head)) begin
            r_head_data <= i_ctrl.id;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_stat.head_id = r_head_data;
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count >= DEPTH_C);

endmodule

>>> rtl/multilevel_feedback_scheduler.sv
// Top level of the three-level feedback scheduler with I/O wait queue.
`timescale 1ns / 1ps

// Takes one command beat per clock while results drain, and returns exactly one
// result beat for each: the command lands in an input register, then one
// pass of queue push/pop and level-pick logic writes the result register and the
// scheduler state together at the next edge. The input register takes one further
// command while a result waits downstream, then holds off until the result goes.
// Queue memories need no clearing pass after reset; entries are only read inside
// each queue's fill count. Slice registers may be written at any time the block
// holds no command.
module multilevel_feedback_scheduler import mfs_pkg::*; #(
    parameter int PROC_COUNT  = PROC_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfs_cmd_if.sink   i_cmd,
    mfs_cfg_if.sink   i_cfg,
    mfs_res_if.source o_res
);

    // Ids are ID_W bits wide, so at most 2**ID_W level records are reachable
    localparam int LVL_SLOTS = (PROC_COUNT < (1 << ID_W)) ? PROC_COUNT : (1 << ID_W);
    localparam int LIDX_W    = (LVL_SLOTS > 1) ? $clog2(LVL_SLOTS) : 1;

    // Input register
    logic            r_in_valid;
    t_op             r_in_op;
    logic [ID_W-1:0] r_in_pid;
    t_outcome        r_in_oc;
    logic            advance;

    // Scheduler state
    logic [SLICE_W-1:0] r_slice [LEVEL_COUNT];
    logic [LVL_W-1:0]   r_plvl  [LVL_SLOTS];
    logic               r_run_valid;
    logic [ID_W-1:0]    r_run_id;

    // Result register
    logic                r_out_valid;
    logic [ID_W-1:0]     r_gid;
    logic [LVL_W-1:0]    r_glev;
    logic [SLICE_W-1:0]  r_gslice;
    logic                r_gvalid;
    t_status             r_status;

    t_q_ctrl q_ctrl [QUEUE_COUNT];
    t_q_stat q_stat [QUEUE_COUNT];

    logic               n_run_valid;
    logic [ID_W-1:0]    n_run_id;
    logic [ID_W-1:0]    n_gid;
    logic [LVL_W-1:0]   n_glev;
    logic [SLICE_W-1:0] n_gslice;
    logic               n_gvalid;
    t_status            n_status;

    logic [ID_W-1:0]    rd_id;
    logic [ID_W-1:0]    rd_slot;
    logic [LVL_W-1:0]   rd_lvl;
    logic [ID_W-1:0]    wr_slot;
    logic               lvl_we;
    logic [LVL_W-1:0]   lvl_wr_val;
    logic [LVL_W-1:0]   pick_lvl;
    logic               pick_any;
    logic [LVL_W-1:0]   step_lvl;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_queue
        mfs_queue #(
            .DEPTH (QUEUE_DEPTH)
        ) u_queue (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (q_ctrl[g]),
            .o_stat  (q_stat[g])
        );
    end

    // One level record read: the running process for a report, else the I/O head
    always_comb begin
        rd_id   = (r_in_op == OP_REPORT) ? r_run_id : q_stat[IO_QUEUE].head_id;
        rd_slot = slot_of(rd_id, PROC_COUNT);
        rd_lvl  = clamp_level(r_plvl[rd_slot[LIDX_W-1:0]]);
    end

    always_comb begin
        pick_any = 1'b1;
        priority if (!q_stat[LVL_TOP].empty) begin
            pick_lvl = LVL_TOP;
        end else if (!q_stat[LVL_MID].empty) begin
            pick_lvl = LVL_MID;
        end else if (!q_stat[LVL_BOTTOM].empty) begin
            pick_lvl = LVL_BOTTOM;
        end else begin
            pick_lvl = LVL_TOP;
            pick_any = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < QUEUE_COUNT; k++) begin
            q_ctrl[k] = '0;
        end
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_gid       = '0;
        n_glev      = '0;
        n_gslice    = '0;
        n_gvalid    = 1'b0;
        n_status    = ST_OK;
        lvl_we      = 1'b0;
        lvl_wr_val  = LVL_TOP;
        wr_slot     = rd_slot;
        step_lvl    = LVL_TOP;
        if (advance) begin
            unique case (r_in_op)
                OP_ADMIT: begin
                    wr_slot = slot_of(r_in_pid, PROC_COUNT);
                    if (q_stat[LVL_TOP].full) begin
                        n_status = ST_FULL;
                    end else begin
                        q_ctrl[LVL_TOP].push = 1'b1;
                        q_ctrl[LVL_TOP].id   = r_in_pid;
                        lvl_we   = 1'b1;
                        n_gid    = r_in_pid;
                        n_gvalid = 1'b1;
                    end
                end
                OP_DISPATCH: begin
                    if (!pick_any) begin
                        n_status = ST_EMPTY;
                    end else begin
                        q_ctrl[pick_lvl].pop = 1'b1;
                        n_run_valid = 1'b1;
                        n_run_id    = q_stat[pick_lvl].head_id;
                        n_gid       = q_stat[pick_lvl].head_id;
                        n_glev      = pick_lvl;
                        n_gslice    = r_slice[pick_lvl];
                        n_gvalid    = 1'b1;
                    end
                end
                OP_REPORT: begin
                    if (!r_run_valid) begin
                        n_status = ST_NORUN;
                    end else begin
                        unique case (r_in_oc)
                            OC_FINISHED: begin
                                n_run_valid = 1'b0;
                                n_gid       = r_run_id;
                                n_glev      = rd_lvl;
                                n_gvalid    = 1'b1;
                            end
                            OC_IO_REQ: begin
                                step_lvl = (rd_lvl == LVL_TOP) ? LVL_TOP
                                                               : rd_lvl - LVL_W'(1);
                                if (q_stat[IO_QUEUE].full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    q_ctrl[IO_QUEUE].push = 1'b1;
                                    q_ctrl[IO_QUEUE].id   = r_run_id;
                                    lvl_we      = 1'b1;
                                    lvl_wr_val  = step_lvl;
                                    n_run_valid = 1'b0;
                                    n_gid       = r_run_id;
                                    n_glev      = step_lvl;
                                    n_gvalid    = 1'b1;
                                end
                            end
                            OC_EXPIRED: begin
                                step_lvl = (rd_lvl >= LVL_BOTTOM) ? LVL_BOTTOM
                                                                  : rd_lvl + LVL_W'(1);
                                if (q_stat[step_lvl].full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    q_ctrl[step_lvl].push = 1'b1;
                                    q_ctrl[step_lvl].id   = r_run_id;
                                    lvl_we      = 1'b1;
                                    lvl_wr_val  = step_lvl;
                                    n_run_valid = 1'b0;
                                    n_gid       = r_run_id;
                                    n_glev      = step_lvl;
                                    n_gvalid    = 1'b1;
                                end
                            end
                            default: begin
                                // unknown outcome: drop, report ok with no process
                                n_status = ST_OK;
                            end
                        endcase
                    end
                end
                OP_IO_DONE: begin
                    if (q_stat[IO_QUEUE].empty) begin
                        n_status = ST_EMPTY;
                    end else if (q_stat[rd_lvl].full) begin
                        n_status = ST_FULL;
                    end else begin
                        q_ctrl[IO_QUEUE].pop = 1'b1;
                        q_ctrl[rd_lvl].push  = 1'b1;
                        q_ctrl[rd_lvl].id    = q_stat[IO_QUEUE].head_id;
                        n_gid    = q_stat[IO_QUEUE].head_id;
                        n_glev   = rd_lvl;
                        n_gvalid = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_slice[0]  <= SLICE0_RST;
            r_slice[1]  <= SLICE1_RST;
            r_slice[2]  <= SLICE2_RST;
            for (int k = 0; k < LVL_SLOTS; k++) begin
                r_plvl[k] <= LVL_TOP;
            end
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            if (lvl_we) begin
                r_plvl[wr_slot[LIDX_W-1:0]] <= lvl_wr_val;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_SLICE_LEVEL0: r_slice[0] <= i_cfg.data;
                    CFG_SLICE_LEVEL1: r_slice[1] <= i_cfg.data;
                    CFG_SLICE_LEVEL2: r_slice[2] <= i_cfg.data;
                    default: begin
                        // no register at this index: ignore the beat
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_op  <= t_op'(i_cmd.operation);
            r_in_pid <= i_cmd.process_id;
            r_in_oc  <= t_outcome'(i_cmd.outcome);
        end
        if (advance) begin
            r_gid    <= n_gid;
            r_glev   <= n_glev;
            r_gslice <= n_gslice;
            r_gvalid <= n_gvalid;
            r_status <= n_status;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.granted_id    = r_gid;
    assign o_res.granted_level = r_glev;
    assign o_res.granted_slice = r_gslice;
    assign o_res.valid_res     = r_gvalid;
    assign o_res.status        = r_status;

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.valid_res) |->
            (o_res.granted_id == '0 && o_res.granted_level == '0 &&
             o_res.granted_slice == '0))
        else $error("result without a process carries non-zero fields");

    a_granted_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.valid_res) |-> (o_res.status == ST_OK))
        else $error("granted process reported with an error status");

    a_run_from_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run_valid) |-> $past(advance && r_in_op == OP_DISPATCH))
        else $error("running process set by something other than dispatch");

    a_io_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat[IO_QUEUE].empty && q_stat[IO_QUEUE].full))
        else $error("I/O queue flagged both empty and full");

endmodule

>>> dv/mfs_grant_checker.sv
// Scheduler checker: mirrors queues, levels and slices, and compares every result beat.
`timescale 1ns / 1ps

module mfs_grant_checker import mfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mfs_cmd_if   cmd,
    mfs_cfg_if   cfg,
    mfs_res_if   res,
    output int   o_pending,
    output int   o_fail_count
);

    localparam int PCOUNT = PROC_COUNT_DEF;
    localparam int QDEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [LVL_W-1:0]    level;
        logic [SLICE_W-1:0]  slice;
        logic                valid_res;
        logic [STATUS_W-1:0] status;
    } t_grant;

    logic [ID_W-1:0]    slot_mem  [QUEUE_COUNT][QDEPTH];
    int                 q_head    [QUEUE_COUNT];
    int                 q_fill    [QUEUE_COUNT];
    logic [LVL_W-1:0]   proc_lvl  [PCOUNT];
    logic               run_valid;
    logic [ID_W-1:0]    run_id;
    logic [SLICE_W-1:0] slice_reg [LEVEL_COUNT];
    t_grant             pending_grants [$];
    int                 n_fail = 0;

    function automatic void clear_state();
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            q_head[q] = 0;
            q_fill[q] = 0;
        end
        for (int p = 0; p < PCOUNT; p++) begin
            proc_lvl[p] = LVL_TOP;
        end
        run_valid    = 1'b0;
        run_id       = '0;
        slice_reg[0] = SLICE0_RST;
        slice_reg[1] = SLICE1_RST;
        slice_reg[2] = SLICE2_RST;
    endfunction

    function automatic void enqueue(input int q, input logic [ID_W-1:0] id);
        slot_mem[q][(q_head[q] + q_fill[q]) % QDEPTH] = id;
        q_fill[q]++;
    endfunction

    function automatic logic [ID_W-1:0] dequeue(input int q);
        logic [ID_W-1:0] id;
        id = slot_mem[q][q_head[q]];
        q_head[q] = (q_head[q] + 1) % QDEPTH;
        q_fill[q]--;
        return id;
    endfunction

    function automatic t_grant predict_grant(input t_op op, input logic [ID_W-1:0] pid,
                                             input logic [OC_W-1:0] oc);
        t_grant           g;
        int               slot;
        logic [LVL_W-1:0] lv;
        logic [LVL_W-1:0] nl;
        logic [ID_W-1:0]  id;
        g = '0;
        g.status = ST_OK;
        case (op)
            OP_ADMIT: begin
                if (q_fill[LVL_TOP] >= QDEPTH) begin
                    g.status = ST_FULL;
                end else begin
                    enqueue(LVL_TOP, pid);
                    proc_lvl[int'(pid) % PCOUNT] = LVL_TOP;
                    g.id        = pid;
                    g.level     = LVL_TOP;
                    g.valid_res = 1'b1;
                end
            end
            OP_DISPATCH: begin
                // IO_QUEUE stands for "nothing ready" here
                lv = IO_QUEUE;
                if (q_fill[LVL_TOP] != 0) begin
                    lv = LVL_TOP;
                end else if (q_fill[LVL_MID] != 0) begin
                    lv = LVL_MID;
                end else if (q_fill[LVL_BOTTOM] != 0) begin
                    lv = LVL_BOTTOM;
                end
                if (lv == IO_QUEUE) begin
                    g.status = ST_EMPTY;
                end else begin
                    id          = dequeue(lv);
                    run_valid   = 1'b1;
                    run_id      = id;
                    g.id        = id;
                    g.level     = lv;
                    g.slice     = slice_reg[lv];
                    g.valid_res = 1'b1;
                end
            end
            OP_REPORT: begin
                if (!run_valid) begin
                    g.status = ST_NORUN;
                end else begin
                    slot = int'(run_id) % PCOUNT;
                    lv   = proc_lvl[slot];
                    if (lv > LVL_BOTTOM) begin
                        lv = LVL_BOTTOM;
                    end
                    case (oc)
                        OC_FINISHED: begin
                            run_valid   = 1'b0;
                            g.id        = run_id;
                            g.level     = lv;
                            g.valid_res = 1'b1;
                        end
                        OC_IO_REQ: begin
                            if (q_fill[IO_QUEUE] >= QDEPTH) begin
                                g.status = ST_FULL;
                            end else begin
                                nl = (lv == LVL_TOP) ? LVL_TOP : lv - LVL_W'(1);
                                proc_lvl[slot] = nl;
                                enqueue(IO_QUEUE, run_id);
                                run_valid   = 1'b0;
                                g.id        = run_id;
                                g.level     = nl;
                                g.valid_res = 1'b1;
                            end
                        end
                        OC_EXPIRED: begin
                            nl = (lv >= LVL_BOTTOM) ? LVL_BOTTOM : lv + LVL_W'(1);
                            if (q_fill[nl] >= QDEPTH) begin
                                g.status = ST_FULL;
                            end else begin
                                proc_lvl[slot] = nl;
                                enqueue(nl, run_id);
                                run_valid   = 1'b0;
                                g.id        = run_id;
                                g.level     = nl;
                                g.valid_res = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                if (q_fill[IO_QUEUE] == 0) begin
                    g.status = ST_EMPTY;
                end else begin
                    // peek first: a full target leaves the head where it is
                    id = slot_mem[IO_QUEUE][q_head[IO_QUEUE]];
                    lv = proc_lvl[int'(id) % PCOUNT];
                    if (lv > LVL_BOTTOM) begin
                        lv = LVL_BOTTOM;
                    end
                    if (q_fill[lv] >= QDEPTH) begin
                        g.status = ST_FULL;
                    end else begin
                        void'(dequeue(IO_QUEUE));
                        enqueue(lv, id);
                        g.id        = id;
                        g.level     = lv;
                        g.valid_res = 1'b1;
                    end
                end
            end
        endcase
        return g;
    endfunction

    function automatic void note_failure(input string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_grant got;
        t_grant want;
        if (!i_rst_n) begin
            clear_state();
            pending_grants.delete();
        end else begin
            if (res.valid && res.ready) begin
                got.id        = res.granted_id;
                got.level     = res.granted_level;
                got.slice     = res.granted_slice;
                got.valid_res = res.valid_res;
                got.status    = res.status;
                if (pending_grants.size() == 0) begin
                    note_failure($sformatf("result beat with nothing outstanding: %p", got));
                end else begin
                    want = pending_grants.pop_front();
                    if (got !== want) begin
                        note_failure($sformatf({"grant mismatch: expected id %0d lvl %0d ",
                            "slice %0d vr %0b st %0d, got id %0d lvl %0d slice %0d ",
                            "vr %0b st %0d"},
                            want.id, want.level, want.slice, want.valid_res, want.status,
                            got.id, got.level, got.slice, got.valid_res, got.status));
                    end
                end
            end
            if (cfg.valid && cfg.ready && cfg.index < LEVEL_COUNT) begin
                slice_reg[cfg.index] = cfg.data;
            end
            if (cmd.valid && cmd.ready) begin
                pending_grants.push_back(predict_grant(t_op'(cmd.operation), cmd.process_id,
                                                       cmd.outcome));
            end
        end
        o_pending    <= pending_grants.size();
        o_fail_count <= n_fail;
    end

endmodule

>>> dv/testbench.sv
// Testbench top: clock, reset, command and slice stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;
    import mfs_pkg::*;

    localparam logic [OC_W-1:0] OC_UNUSED = 2'd3;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 100;

    // per phase: op mix (admit, dispatch, report, io done) and outcome mix
    int admit_w [PHASES] = '{70, 45, 20, 50, 15};
    int disp_w  [PHASES] = '{10, 20, 30, 15, 35};
    int rep_w   [PHASES] = '{10, 30, 20, 20, 20};
    int fin_w   [PHASES] = '{10, 30, 30, 10, 40};
    int ioreq_w [PHASES] = '{20, 40, 30, 10, 30};

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    bit   quiet;
    bit   squeeze_req;

    mfs_cmd_if cmd_ch ();
    mfs_cfg_if cfg_ch ();
    mfs_res_if res_ch ();

    multilevel_feedback_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    mfs_grant_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd          (cmd_ch),
        .cfg          (cfg_ch),
        .res          (res_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_op pick_op(input int p);
        int r;
        r = $urandom_range(0, 99);
        if (r < admit_w[p]) return OP_ADMIT;
        if (r < admit_w[p] + disp_w[p]) return OP_DISPATCH;
        if (r < admit_w[p] + disp_w[p] + rep_w[p]) return OP_REPORT;
        return OP_IO_DONE;
    endfunction

    function automatic logic [OC_W-1:0] pick_outcome(input int p);
        int r;
        r = $urandom_range(0, 99);
        if (r < fin_w[p]) return OC_FINISHED;
        if (r < fin_w[p] + ioreq_w[p]) return OC_IO_REQ;
        if (r < 97) return OC_EXPIRED;
        return OC_UNUSED;
    endfunction

    // Hold valid with the beat until it is taken; leave valid high for the next one.
    task automatic send_cmd(input t_op op, input logic [ID_W-1:0] pid,
                            input logic [OC_W-1:0] oc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.process_id <= pid;
        cmd_ch.outcome    <= oc;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLICE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_slices(input logic [SLICE_W-1:0] s0, s1, s2);
        wait_idle();
        write_reg(CFG_SLICE_LEVEL0, s0);
        write_reg(CFG_SLICE_LEVEL1, s1);
        write_reg(CFG_SLICE_LEVEL2, s2);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : res_ready_drive
        int seg;
        int mode;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (squeeze_req) begin
                // long hold-off: let the block fill and push back on commands
                squeeze_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (150) @(posedge i_clk);
            end else begin
                seg  = $urandom_range(1, 40);
                mode = $urandom_range(0, 99);
                if (mode < 3) begin
                    res_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 40)) @(posedge i_clk);
                end else begin
                    repeat (seg) begin
                        if (mode < 40) begin
                            res_ch.ready <= 1'b1;
                        end else if (mode < 80) begin
                            res_ch.ready <= 1'($urandom_range(0, 1));
                        end else begin
                            res_ch.ready <= ($urandom_range(0, 3) == 0);
                        end
                        @(posedge i_clk);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int sent;
        quiet       = 1'b0;
        squeeze_req = 1'b0;
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.operation  <= OP_ADMIT;
        cmd_ch.process_id <= '0;
        cmd_ch.outcome    <= OC_FINISHED;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_SLICE_LEVEL0;
        cfg_ch.data       <= SLICE0_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty scheduler: nothing to dispatch, nothing running, no I/O pending
        send_cmd(OP_DISPATCH, 3'd0, OC_FINISHED);
        send_cmd(OP_REPORT,   3'd0, OC_FINISHED);
        send_cmd(OP_IO_DONE,  3'd0, OC_FINISHED);
        send_cmd(OP_ADMIT,    3'd0, OC_FINISHED);
        send_cmd(OP_ADMIT,    3'd7, OC_IO_REQ);
        send_cmd(OP_ADMIT,    3'd5, OC_EXPIRED);
        send_cmd(OP_ADMIT,    3'd5, OC_UNUSED);
        send_cmd(OP_DISPATCH, 3'd2, OC_FINISHED);
        send_cmd(OP_REPORT,   3'd0, OC_UNUSED);
        send_cmd(OP_REPORT,   3'd0, OC_EXPIRED);
        send_cmd(OP_DISPATCH, 3'd0, OC_FINISHED);
        send_cmd(OP_REPORT,   3'd0, OC_IO_REQ);
        send_cmd(OP_IO_DONE,  3'd0, OC_FINISHED);
        send_cmd(OP_DISPATCH, 3'd0, OC_FINISHED);
        send_cmd(OP_DISPATCH, 3'd0, OC_FINISHED);
        send_cmd(OP_REPORT,   3'd0, OC_FINISHED);
        // overfill the top level
        for (int k = 0; k < 10; k++) begin
            send_cmd(OP_ADMIT, 3'(k), OC_FINISHED);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       write_slices(8'd255, 8'd255, 8'd255);
                1:       write_slices(8'd1, 8'd1, 8'd1);
                2:       write_slices(8'd1, 8'd255, 8'($urandom_range(1, 255)));
                default: write_slices(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                      8'($urandom_range(1, 255)));
            endcase
            quiet = (p == 2);
            if (p == 1) begin
                squeeze_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 60) begin
                    send_cmd(OP_DISPATCH, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
                    send_cmd(OP_REPORT, 3'($urandom_range(0, 7)), pick_outcome(p));
                    sent += 2;
                end else begin
                    send_cmd(pick_op(p), 3'($urandom_range(0, 7)), pick_outcome(p));
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/mfs_pkg.sv
rtl/mfs_if.sv
rtl/mfs_queue.sv
rtl/multilevel_feedback_scheduler.sv
dv/mfs_grant_checker.sv
dv/testbench.sv
